// File: rtl/core/adlp_pkg.sv
// Package for the AdaGrad L1 proximal update block.
// Holds the transaction payload types, the per-item context and fixed widths.
// No dependencies.
package adlp_pkg;

   localparam int unsigned DATA_BITS = 32;
   localparam int unsigned ACC_BITS  = 48;
   localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] weight;
      logic signed [DATA_BITS-1:0] gradient;
      logic [ACC_BITS-1:0]         accum;
      logic                        last_element;
   } req_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] new_weight;
      logic [ACC_BITS-1:0]         new_accum;
      logic                        last;
   } rsp_type;

   // per-item data carried beside the root and divide pipelines
   typedef struct packed {
      logic signed [DATA_BITS-1:0] weight;
      logic                        gneg;
      logic                        gzero;
      logic [DATA_BITS-1:0]        gmag;
      logic [ACC_BITS-1:0]         accum;
      logic [2*DATA_BITS-1:0]      sq;
      logic                        last;
   } ctx_type;

endpackage

// File: rtl/core/adlp_sqrt.sv
// Square root pipeline: one radicand bit pair per stage, floor(sqrt(accum * 2^F)).
// Also forms |gradient|, gradient^2 and the saturated new accumulator on the way.
// Depends on adlp_pkg.
module adlp_sqrt #(
   parameter int unsigned FRAC_BITS = 16,
   localparam int unsigned P = (adlp_pkg::ACC_BITS + FRAC_BITS + 1) / 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  adlp_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output adlp_pkg::ctx_type out_ctx,
   output logic [P-1:0]      out_root
);
   import adlp_pkg::*;

   localparam int unsigned RMW  = P + 3;
   localparam int unsigned RADW = 2 * P;

   logic            vld_ff  [P];
   logic            vld_pre [P];
   logic            rdy     [P+1];
   logic [RMW-1:0]  rem_ff  [P];
   logic [RMW-1:0]  rem_pre [P];
   logic [RMW-1:0]  rem_in  [P];
   logic [P-1:0]    root_ff [P];
   logic [P-1:0]    root_pre[P];
   logic [P-1:0]    root_in [P];
   logic [RADW-1:0] rad_ff  [P];
   logic [RADW-1:0] rad_pre [P];
   logic [RADW-1:0] rad_in  [P];
   ctx_type         ctx_ff  [P];
   ctx_type         ctx_pre [P];
   ctx_type         ctx_in  [P];

   always_comb begin
      logic [RMW-1:0]          remsh;
      logic [RMW-1:0]          trial;
      logic [2*DATA_BITS-1:0]  sq_sh;
      logic [2*DATA_BITS:0]    sum;
      rdy[P] = out_ready;
      for (int k = P - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_pre[0]        = in_valid;
      rem_pre[0]        = '0;
      root_pre[0]       = '0;
      rad_pre[0]        = RADW'(in_data.accum) << FRAC_BITS;
      ctx_pre[0].weight = in_data.weight;
      ctx_pre[0].gneg   = in_data.gradient[DATA_BITS-1];
      ctx_pre[0].gzero  = (in_data.gradient == '0);
      ctx_pre[0].gmag   = in_data.gradient[DATA_BITS-1] ?
                          DATA_BITS'(-in_data.gradient) : DATA_BITS'(in_data.gradient);
      ctx_pre[0].accum  = in_data.accum;
      ctx_pre[0].sq     = '0;
      ctx_pre[0].last   = in_data.last_element;
      for (int k = 1; k < P; k++) begin
         vld_pre[k]  = vld_ff[k-1];
         rem_pre[k]  = rem_ff[k-1];
         root_pre[k] = root_ff[k-1];
         rad_pre[k]  = rad_ff[k-1];
         ctx_pre[k]  = ctx_ff[k-1];
      end
      for (int k = 0; k < P; k++) begin
         remsh = {rem_pre[k][RMW-3:0], rad_pre[k][RADW-1 -: 2]};
         trial = {1'b0, root_pre[k], 2'b01};
         if (remsh >= trial) begin
            rem_in[k]  = remsh - trial;
            root_in[k] = {root_pre[k][P-2:0], 1'b1};
         end else begin
            rem_in[k]  = remsh;
            root_in[k] = {root_pre[k][P-2:0], 1'b0};
         end
         rad_in[k] = rad_pre[k] << 2;
         ctx_in[k] = ctx_pre[k];
         sq_sh     = ctx_pre[k].sq >> FRAC_BITS;
         sum       = (2*DATA_BITS+1)'(ctx_pre[k].accum) + (2*DATA_BITS+1)'(sq_sh);
         if (k == 1) begin
            ctx_in[k].sq = (2*DATA_BITS)'(ctx_pre[k].gmag) * (2*DATA_BITS)'(ctx_pre[k].gmag);
         end
         if (k == 2) begin
            ctx_in[k].accum = (sum > (2*DATA_BITS+1)'(ACC_MAX)) ? ACC_MAX : sum[ACC_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < P; k++) vld_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < P; k++) if (rdy[k]) vld_ff[k] <= vld_pre[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < P; k++) begin
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            ctx_ff[k]  <= ctx_in[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[P-1];
   assign out_ctx   = ctx_ff[P-1];
   assign out_root  = root_ff[P-1];

endmodule

// File: rtl/core/adlp_div.sv
// Restoring divider pipeline: step = floor(learn_rate * 2^F / (2^F + root)),
// one quotient bit per stage. Depends on adlp_pkg.
module adlp_div #(
   parameter int unsigned FRAC_BITS = 16,
   localparam int unsigned P = (adlp_pkg::ACC_BITS + FRAC_BITS + 1) / 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  adlp_pkg::ctx_type                 in_ctx,
   input  logic [P-1:0]                      in_root,
   input  logic [adlp_pkg::DATA_BITS-1:0]    learn_rate,
   output logic                              out_valid,
   input  logic                              out_ready,
   output adlp_pkg::ctx_type                 out_ctx,
   output logic [adlp_pkg::DATA_BITS-1:0]    out_step
);
   import adlp_pkg::*;

   localparam int unsigned N  = DATA_BITS;
   localparam int unsigned DW = P + 1;

   logic                 vld_ff [N];
   logic                 vld_pre[N];
   logic                 rdy    [N+1];
   logic [DW:0]          rem_ff [N];
   logic [DW:0]          rem_pre[N];
   logic [DW:0]          rem_in [N];
   logic [DW-1:0]        den_ff [N];
   logic [DW-1:0]        den_pre[N];
   logic [DATA_BITS-1:0] dlo_ff [N];
   logic [DATA_BITS-1:0] dlo_pre[N];
   logic [DATA_BITS-1:0] q_ff   [N];
   logic [DATA_BITS-1:0] q_pre  [N];
   logic [DATA_BITS-1:0] q_in   [N];
   ctx_type              ctx_ff [N];
   ctx_type              ctx_pre[N];

   always_comb begin
      logic [DW:0] remsh;
      rdy[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_pre[0] = in_valid;
      rem_pre[0] = (DW+1)'(learn_rate >> (DATA_BITS - FRAC_BITS));
      den_pre[0] = DW'(in_root) + (DW'(1) << FRAC_BITS);
      dlo_pre[0] = DATA_BITS'(learn_rate << FRAC_BITS);
      q_pre[0]   = '0;
      ctx_pre[0] = in_ctx;
      for (int k = 1; k < N; k++) begin
         vld_pre[k] = vld_ff[k-1];
         rem_pre[k] = rem_ff[k-1];
         den_pre[k] = den_ff[k-1];
         dlo_pre[k] = dlo_ff[k-1];
         q_pre[k]   = q_ff[k-1];
         ctx_pre[k] = ctx_ff[k-1];
      end
      for (int k = 0; k < N; k++) begin
         remsh = {rem_pre[k][DW-1:0], dlo_pre[k][DATA_BITS-1]};
         if (remsh >= {1'b0, den_pre[k]}) begin
            rem_in[k] = remsh - {1'b0, den_pre[k]};
            q_in[k]   = {q_pre[k][DATA_BITS-2:0], 1'b1};
         end else begin
            rem_in[k] = remsh;
            q_in[k]   = {q_pre[k][DATA_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) vld_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < N; k++) if (rdy[k]) vld_ff[k] <= vld_pre[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (rdy[k]) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_pre[k];
            dlo_ff[k] <= dlo_pre[k] << 1;
            q_ff[k]   <= q_in[k];
            ctx_ff[k] <= ctx_pre[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[N-1];
   assign out_ctx   = ctx_ff[N-1];
   assign out_step  = q_ff[N-1];

endmodule

// File: rtl/core/adlp_post.sv
// Update stages: step products, moved weight, L1 shrink, sign and saturation.
// Last stage is the result register. Depends on adlp_pkg.
module adlp_post #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  adlp_pkg::ctx_type              in_ctx,
   input  logic [adlp_pkg::DATA_BITS-1:0] in_step,
   input  logic [adlp_pkg::DATA_BITS-1:0] l1_strength,
   output logic                           out_valid,
   input  logic                           out_ready,
   output adlp_pkg::rsp_type              out_data
);
   import adlp_pkg::*;

   localparam int unsigned PW = 2 * DATA_BITS;
   localparam int unsigned UW = PW + 2;
   localparam logic [PW-1:0] POS_MAX = PW'({1'b0, {(DATA_BITS-1){1'b1}}});
   localparam logic [PW-1:0] NEG_MAX = PW'({1'b1, {(DATA_BITS-1){1'b0}}});

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1, r2, r3, r4;

   ctx_type              c1_ff, c2_ff, c3_ff;
   logic [PW-1:0]        mvp_ff, thrp_ff;
   logic signed [UW-1:0] u_ff, u_in;
   logic [PW-1:0]        thr_ff;
   logic                 uneg_ff;
   logic [PW-1:0]        mag_ff, mag_in;
   rsp_type              rsp_ff, rsp_in;

   always_comb begin
      logic signed [UW-1:0] ws;
      logic signed [UW-1:0] mvs;
      logic [PW-1:0]        umag;
      ws   = UW'(c1_ff.weight);
      mvs  = signed'({2'b00, mvp_ff >> FRAC_BITS});
      u_in = c1_ff.gneg ? ws + mvs : ws - mvs;
      umag = u_ff[UW-1] ? PW'(-u_ff) : PW'(u_ff);
      mag_in = (umag > thr_ff) ? umag - thr_ff : '0;
      rsp_in.new_accum = c3_ff.accum;
      rsp_in.last      = c3_ff.last;
      if (c3_ff.gzero) begin
         rsp_in.new_weight = c3_ff.weight;
      end else if (uneg_ff) begin
         rsp_in.new_weight = (mag_ff > NEG_MAX) ? DATA_BITS'(-NEG_MAX) :
                             DATA_BITS'(-mag_ff);
      end else begin
         rsp_in.new_weight = (mag_ff > POS_MAX) ? DATA_BITS'(POS_MAX) :
                             DATA_BITS'(mag_ff);
      end
   end

   assign r4 = !v4_ff || out_ready;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         c1_ff   <= in_ctx;
         mvp_ff  <= PW'(in_step) * PW'(in_ctx.gmag);
         thrp_ff <= PW'(l1_strength) * PW'(in_step);
      end
      if (r2) begin
         c2_ff  <= c1_ff;
         u_ff   <= u_in;
         thr_ff <= thrp_ff >> FRAC_BITS;
      end
      if (r3) begin
         c3_ff   <= c2_ff;
         uneg_ff <= u_ff[UW-1];
         mag_ff  <= mag_in;
      end
      if (r4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign in_ready  = r1;
   assign out_valid = v4_ff;
   assign out_data  = rsp_ff;

endmodule

// File: rtl/core/adagrad_l1_prox_update.sv
// Top level of the AdaGrad L1 proximal update block: CSR registers and pipeline.
// Depends on adlp_pkg, adlp_sqrt, adlp_div and adlp_post.
//
//   channel  | ports                        | moves
//   ---------+------------------------------+---------------------------------
//   request  | req_valid/req_ready/req_data | weight, gradient, accum, last
//   response | rsp_valid/rsp_ready/rsp_data | new_weight, new_accum, last
//   csr      | csr_p* (APB style)           | learn_rate @0x0, l1_strength @0x4
//
// One transaction per cycle sustained while rsp_ready is high. With
// P = (48 + FRAC_BITS + 1) / 2 there are P root stages, 32 divide
// stages and 4 update stages. Every stage holds on its own ready, so bubbles
// fill while the response waits. Reset (synchronous) empties the pipeline and
// loads learn_rate = 6554, l1_strength = 0.
module adagrad_l1_prox_update #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  adlp_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output adlp_pkg::rsp_type              rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [adlp_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic [adlp_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                           csr_pready
);
   import adlp_pkg::*;

   localparam int unsigned P = (ACC_BITS + FRAC_BITS + 1) / 2;
   localparam logic REG_LEARN_RATE  = 1'b0;
   localparam logic REG_L1_STRENGTH = 1'b1;
   localparam logic [DATA_BITS-1:0] LEARN_RATE_RESET = DATA_BITS'(6554);

   logic [DATA_BITS-1:0] learn_rate_ff;
   logic [DATA_BITS-1:0] l1_strength_ff;
   logic                 csr_wr;

   logic         sq_valid, sq_ready;
   ctx_type      sq_ctx;
   logic [P-1:0] sq_root;

   logic                 dv_valid, dv_ready;
   ctx_type              dv_ctx;
   logic [DATA_BITS-1:0] dv_step;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff  <= LEARN_RATE_RESET;
         l1_strength_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_LEARN_RATE:  learn_rate_ff  <= csr_pwdata;
            REG_L1_STRENGTH: l1_strength_ff <= csr_pwdata;
            default:         learn_rate_ff  <= learn_rate_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_LEARN_RATE:  csr_prdata = learn_rate_ff;
         REG_L1_STRENGTH: csr_prdata = l1_strength_ff;
         default:         csr_prdata = '0;
      endcase
   end

   adlp_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_ctx   (sq_ctx),
      .out_root  (sq_root)
   );

   adlp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sq_valid),
      .in_ready   (sq_ready),
      .in_ctx     (sq_ctx),
      .in_root    (sq_root),
      .learn_rate (learn_rate_ff),
      .out_valid  (dv_valid),
      .out_ready  (dv_ready),
      .out_ctx    (dv_ctx),
      .out_step   (dv_step)
   );

   adlp_post #(.FRAC_BITS(FRAC_BITS)) u_post (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dv_valid),
      .in_ready    (dv_ready),
      .in_ctx      (dv_ctx),
      .in_step     (dv_step),
      .l1_strength (l1_strength_ff),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_data    (rsp_data)
   );

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while response register is empty");

   a_lr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == REG_LEARN_RATE) |=> learn_rate_ff == $past(csr_pwdata))
      else $error("learn_rate write lost");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

// File: tb/tb_adagrad_l1_prox_update.sv
// Testbench for adagrad_l1_prox_update: directed, random and back-pressure tests.
// A built-in predictor checks every response against the oldest expected one.
// Depends on adlp_pkg and the adagrad_l1_prox_update RTL.
module tb_adagrad_l1_prox_update;
   import adlp_pkg::*;

   localparam int unsigned FRAC      = 16;
   localparam int          DRAIN     = 120;
   localparam int          STALL_MAX = 20000;
   localparam int          HOLD_LEN  = 300;
   localparam logic [2:0]  ADDR_LEARN_RATE = 3'd0;
   localparam logic [2:0]  ADDR_L1_STRENGTH = 3'd4;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [31:0] learn_rate_q;
   logic [31:0] l1_strength_q;
   rsp_type     pending_updates[$];
   int          mismatches;
   int          send_idle_pct;
   int          recv_idle_pct;
   logic        hold_go;
   logic        hold_seen;
   int          hold_cnt;
   int          quiet_cycles;

   adagrad_l1_prox_update #(.FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] scaled_root(logic [47:0] acc);
      logic [63:0] x;
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] trial;
      x = {acc, 16'b0};
      rem = '0;
      root = '0;
      for (int k = 31; k >= 0; k--) begin
         rem = (rem << 2) | 64'(x[2*k+1 -: 2]);
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[31:0];
   endfunction

   function automatic rsp_type prox_update(req_type d);
      rsp_type            r;
      logic signed [63:0] ws;
      logic signed [63:0] gs;
      logic signed [63:0] u;
      logic [63:0]        gmag;
      logic [63:0]        sq;
      logic [63:0]        nacc;
      logic [63:0]        den;
      logic [63:0]        step;
      logic [63:0]        mv;
      logic [63:0]        thr;
      logic [63:0]        umag;
      logic [63:0]        mag;
      ws = 64'(d.weight);
      gs = 64'(d.gradient);
      gmag = (gs < 0) ? -gs : gs;
      sq = (gmag * gmag) >> FRAC;
      nacc = {16'b0, d.accum} + sq;
      if (nacc > {16'b0, ACC_MAX}) nacc = {16'b0, ACC_MAX};
      r.new_accum = nacc[47:0];
      r.last = d.last_element;
      r.new_weight = d.weight;
      if (gs != 0) begin
         den = (64'd1 << FRAC) + {32'b0, scaled_root(d.accum)};
         step = ({32'b0, learn_rate_q} << FRAC) / den;
         mv = (step * gmag) >> FRAC;
         u = (gs < 0) ? ws + $signed(mv) : ws - $signed(mv);
         thr = ({32'b0, l1_strength_q} * step) >> FRAC;
         umag = (u < 0) ? -u : u;
         mag = (umag > thr) ? umag - thr : 64'd0;
         if (u < 0) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            r.new_weight = 32'(-$signed(mag));
         end else begin
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            r.new_weight = mag[31:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // predict on request acceptance, check on response acceptance
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid && req_ready)
         pending_updates.push_back(prox_update(req_data));
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_updates.size() == 0) begin
            report_mismatch("unexpected transaction", {16'b0, rsp_data.new_accum}, '0);
         end else begin
            want = pending_updates.pop_front();
            if (rsp_data.new_weight !== want.new_weight)
               report_mismatch("new_weight", 64'(rsp_data.new_weight),
                               64'(want.new_weight));
            if (rsp_data.new_accum !== want.new_accum)
               report_mismatch("new_accum", 64'(rsp_data.new_accum), 64'(want.new_accum));
            if (rsp_data.last !== want.last)
               report_mismatch("last", 64'(rsp_data.last), 64'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("** adagrad_l1_prox_update: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_go && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_cnt <= HOLD_LEN;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_txn(req_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_update(logic [31:0] w, logic [31:0] g, logic [47:0] acc, logic lst);
      req_type d;
      d.weight = w;
      d.gradient = g;
      d.accum = acc;
      d.last_element = lst;
      send_txn(d);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_LEARN_RATE) learn_rate_q = data;
      if (addr == ADDR_L1_STRENGTH) l1_strength_q = data;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_rates(logic [31:0] lr, logic [31:0] l1);
      drain();
      csr_write(ADDR_LEARN_RATE, lr);
      csr_write(ADDR_L1_STRENGTH, l1);
   endtask

   task automatic test_directed();
      send_update(32'h0001_0000, 32'h0000_8000, 48'd0, 1'b0);
      send_update(32'h7FFF_FFFF, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_update(32'h8000_0000, 32'h7FFF_FFFF, 48'd0, 1'b0);
      send_update(32'hFFFF_0000, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
      send_update(32'h1234_5678, 32'hFFFF_FFFF, 48'h0000_0001_0000, 1'b0);
      send_update(32'h0000_0000, 32'h0000_0001, 48'hFFFF_FFFF_0000, 1'b0);
      set_rates(32'hFFFF_FFFF, 32'h0);
      send_update(32'h7FFF_FFFF, 32'h8000_0000, 48'd0, 1'b0);
      send_update(32'h8000_0000, 32'h7FFF_FFFF, 48'd0, 1'b1);
      send_update(32'h0000_0000, 32'hFFFF_0000, 48'd5, 1'b0);
      send_update(32'h4000_0000, 32'h0001_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
      set_rates(32'h0001_0000, 32'hFFFF_FFFF);
      send_update(32'h0001_0000, 32'h0000_0100, 48'd0, 1'b0);
      send_update(32'hFFFF_0000, 32'hFFFF_FF00, 48'd0, 1'b1);
      send_update(32'h7FFF_FFFF, 32'h0000_0001, 48'h0000_0100_0000, 1'b0);
      send_update(32'h8000_0000, 32'h0000_0000, 48'd0, 1'b0);
      set_rates(32'h0, 32'h0001_0000);
      send_update(32'h0001_2345, 32'h0010_0000, 48'd77, 1'b1);
      send_update(32'hFFFE_0000, 32'hFFF0_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
   endtask

   function automatic req_type random_update();
      req_type d;
      case ($urandom_range(3))
         0: d.weight = $urandom;
         1: d.weight = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
         2: d.weight = $urandom_range(1) ? 32'h7FFF_FF00 + $urandom_range(255)
                                         : 32'h8000_0000 + $urandom_range(255);
         default: d.weight = $signed($urandom_range(255)) - 128;
      endcase
      case ($urandom_range(9))
         0: d.gradient = '0;
         1, 2: d.gradient = $urandom;
         3: d.gradient = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: d.gradient = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      endcase
      case ($urandom_range(3))
         0: d.accum = 48'({$urandom, $urandom} >> 16);
         1: d.accum = ACC_MAX - 48'($urandom_range(32'hFFFF));
         2: d.accum = 48'($urandom_range(32'h00FF_FFFF));
         default: d.accum = 48'({$urandom_range(255), $urandom});
      endcase
      d.last_element = ($urandom_range(15) == 0);
      return d;
   endfunction

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         if (i == n / 2)
            set_rates($urandom, $urandom_range(1) ? $urandom_range(32'h0002_0000) : $urandom);
         send_txn(random_update());
      end
   endtask

   task automatic test_backpressure();
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_go = 1'b1;
      for (int i = 0; i < 160; i++) send_txn(random_update());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      learn_rate_q = 32'd6554;
      l1_strength_q = 32'd0;
      mismatches = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_go = 1'b0;
      hold_seen = 1'b0;
      hold_cnt = 0;
      quiet_cycles = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      send_idle_pct = 28;
      recv_idle_pct = 77;
      set_rates(32'd6554, 32'd0);
      test_random(400);
      send_idle_pct = 77;
      recv_idle_pct = 28;
      set_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      test_random(400);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_rates(32'd0, 32'd0);
      test_random(400);
      test_backpressure();
      drain();

      if (mismatches == 0) begin
         $display("** adagrad_l1_prox_update: PASSED **");
      end else begin
         $display("** adagrad_l1_prox_update: FAILED **");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/adlp_pkg.sv
rtl/core/adlp_sqrt.sv
rtl/core/adlp_div.sv
rtl/core/adlp_post.sv
rtl/core/adagrad_l1_prox_update.sv
tb/tb_adagrad_l1_prox_update.sv
